// ----- rtl/qrt_pkg.sv -----
// qrt_pkg: shared widths, register indexes and payload types for the
// quaternion rigid transform core; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package qrt_pkg;

  localparam int CW  = 32;
  localparam int QCW = 16;
  localparam int MW  = 2 * QCW + 2;
  localparam int NW  = 2 * QCW + 1;
  localparam int PW  = MW + CW;
  localparam int AW  = PW + 2;
  localparam int QW  = AW - 1;
  localparam int RW  = NW;
  localparam int IW  = 3;
  localparam int ROT_W_RESET = 16384;

  typedef enum logic [IW-1:0] {
    CFG_ROT_W   = 3'd0,
    CFG_ROT_X   = 3'd1,
    CFG_ROT_Y   = 3'd2,
    CFG_ROT_Z   = 3'd3,
    CFG_SHIFT_X = 3'd4,
    CFG_SHIFT_Y = 3'd5,
    CFG_SHIFT_Z = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic          kind;
    logic [CW-1:0] in_x;
    logic [CW-1:0] in_y;
    logic [CW-1:0] in_z;
  } in_t;

  typedef struct packed {
    logic [CW-1:0] out_x;
    logic [CW-1:0] out_y;
    logic [CW-1:0] out_z;
    logic          degenerate;
    logic          saturated;
  } out_t;

  typedef struct packed {
    logic [2:0][2:0][MW-1:0] mat;
    logic [NW-1:0]           n;
    logic                    degen;
    logic [2:0][CW-1:0]      shift;
  } pose_t;

  typedef struct packed {
    logic [2:0][RW-1:0] rem;
    logic [2:0][QW-1:0] mq;
    logic [2:0]         neg;
    logic               kind;
    logic               degen;
  } div_item_t;

endpackage
`default_nettype wire

// ----- rtl/qrt_pose.sv -----
// qrt_pose: pose registers and rotation matrix / norm derived from them
// depends on qrt_pkg
`timescale 1ns / 1ps
`default_nettype none
module qrt_pose import qrt_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_we,
  input  wire logic [IW-1:0] cfg_idx,
  input  wire logic [CW-1:0] cfg_data,
  output pose_t              pose
);

  logic [3:0][QCW-1:0] rot_r;
  logic [2:0][CW-1:0]  shift_r;
  logic [2:0][2:0][MW-1:0] mat_r;
  logic [NW-1:0] n_r;
  logic          degen_r;

  logic signed [QCW-1:0] w, a, b, c;
  logic signed [2*QCW-1:0] ww, aa, bb, cc, ab, wc, ac, wb, bc, wa;
  logic signed [MW-1:0] s;
  logic [2:0][2:0][MW-1:0] mat_nxt;
  logic [NW-1:0] n_nxt;

  function automatic logic [MW-1:0] dbl(input logic signed [2*QCW-1:0] x,
                                        input logic signed [2*QCW-1:0] y,
                                        input logic sub);
    logic signed [MW-1:0] t;
    t = sub ? (MW'(x) - MW'(y)) : (MW'(x) + MW'(y));
    return t + t;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_r[0] <= QCW'(ROT_W_RESET);
      rot_r[1] <= '0;
      rot_r[2] <= '0;
      rot_r[3] <= '0;
      shift_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_idx))
        CFG_ROT_W:   rot_r[0] <= cfg_data[QCW-1:0];
        CFG_ROT_X:   rot_r[1] <= cfg_data[QCW-1:0];
        CFG_ROT_Y:   rot_r[2] <= cfg_data[QCW-1:0];
        CFG_ROT_Z:   rot_r[3] <= cfg_data[QCW-1:0];
        CFG_SHIFT_X: shift_r[0] <= cfg_data;
        CFG_SHIFT_Y: shift_r[1] <= cfg_data;
        CFG_SHIFT_Z: shift_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    w  = $signed(rot_r[0]);
    a  = $signed(rot_r[1]);
    b  = $signed(rot_r[2]);
    c  = $signed(rot_r[3]);
    ww = w * w;
    aa = a * a;
    bb = b * b;
    cc = c * c;
    ab = a * b;
    wc = w * c;
    ac = a * c;
    wb = w * b;
    bc = b * c;
    wa = w * a;
    s  = MW'(ww) - MW'(aa) - MW'(bb) - MW'(cc);
    mat_nxt[0][0] = s + MW'(aa) + MW'(aa);
    mat_nxt[0][1] = dbl(ab, wc, 1'b1);
    mat_nxt[0][2] = dbl(ac, wb, 1'b0);
    mat_nxt[1][0] = dbl(ab, wc, 1'b0);
    mat_nxt[1][1] = s + MW'(bb) + MW'(bb);
    mat_nxt[1][2] = dbl(bc, wa, 1'b1);
    mat_nxt[2][0] = dbl(ac, wb, 1'b1);
    mat_nxt[2][1] = dbl(bc, wa, 1'b0);
    mat_nxt[2][2] = s + MW'(cc) + MW'(cc);
    n_nxt = NW'($unsigned(ww)) + NW'($unsigned(aa)) + NW'($unsigned(bb))
          + NW'($unsigned(cc));
  end

  always_ff @(posedge clk) begin
    mat_r   <= mat_nxt;
    n_r     <= n_nxt;
    degen_r <= (n_nxt == '0);
  end

  assign pose.mat   = mat_r;
  assign pose.n     = n_r;
  assign pose.degen = degen_r;
  assign pose.shift = shift_r;

endmodule
`default_nettype wire

// ----- rtl/qrt_mac.sv -----
// qrt_mac: input register, matrix-vector products and row sums with sign split
// depends on qrt_pkg
`timescale 1ns / 1ps
`default_nettype none
module qrt_mac import qrt_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire pose_t     pose,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_t       in_data,
  output logic           dn_valid,
  input  wire logic      dn_ready,
  output div_item_t      dn_item
);

  logic v1_r, v2_r, v3_r, v4_r;
  logic adv1, adv2, adv3, adv4;
  in_t  d1_r, d2_r;
  logic [2:0][2:0][PW-1:0] prod_r;
  logic kind3_r;
  div_item_t item_r;

  logic [2:0][CW-1:0] vec;
  logic [2:0][2:0][PW-1:0] prod_nxt;
  div_item_t item_nxt;
  logic signed [AW-1:0] sum;

  assign adv4 = !v4_r || dn_ready;
  assign adv3 = !v3_r || adv4;
  assign adv2 = !v2_r || adv3;
  assign adv1 = !v1_r || adv2;
  assign in_ready = adv1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
      if (adv4) v4_r <= v3_r;
    end
  end

  always_comb begin
    vec[0] = d2_r.in_x;
    vec[1] = d2_r.in_y;
    vec[2] = d2_r.in_z;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_nxt[i][j] = PW'($signed(pose.mat[i][j])) * PW'($signed(vec[j]));
      end
    end
  end

  always_comb begin
    item_nxt       = '0;
    item_nxt.kind  = kind3_r;
    item_nxt.degen = pose.degen;
    for (int i = 0; i < 3; i++) begin
      sum = AW'($signed(prod_r[i][0])) + AW'($signed(prod_r[i][1]))
          + AW'($signed(prod_r[i][2]));
      item_nxt.neg[i] = sum[AW-1];
      item_nxt.mq[i]  = sum[AW-1] ? QW'(-sum) : QW'(sum);
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) d1_r <= in_data;
    if (adv2) d2_r <= d1_r;
    if (adv3) begin
      prod_r  <= prod_nxt;
      kind3_r <= d2_r.kind;
    end
    if (adv4) item_r <= item_nxt;
  end

  assign dn_valid = v4_r;
  assign dn_item  = item_r;

endmodule
`default_nettype wire

// ----- rtl/qrt_div.sv -----
// qrt_div: restoring divider, one quotient bit per pipeline stage, three lanes
// depends on qrt_pkg
`timescale 1ns / 1ps
`default_nettype none
module qrt_div import qrt_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic [NW-1:0] n,
  input  wire logic    up_valid,
  output logic         up_ready,
  input  wire div_item_t up_item,
  output logic         dn_valid,
  input  wire logic    dn_ready,
  output div_item_t    dn_item
);

  logic      vld_r [QW];
  logic      adv   [QW];
  div_item_t st_r  [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    div_item_t src, nxt;
    logic      src_v;
    logic [RW-1:0] t;

    if (k == 0) begin : g_first
      assign src   = up_item;
      assign src_v = up_valid;
    end else begin : g_next
      assign src   = st_r[k-1];
      assign src_v = vld_r[k-1];
    end

    if (k == QW - 1) begin : g_last
      assign adv[k] = !vld_r[k] || dn_ready;
    end else begin : g_mid
      assign adv[k] = !vld_r[k] || adv[k+1];
    end

    always_comb begin
      nxt = src;
      t   = '0;
      for (int i = 0; i < 3; i++) begin
        t = {src.rem[i][RW-2:0], src.mq[i][QW-1]};
        if (t >= n) begin
          nxt.rem[i] = t - n;
          nxt.mq[i]  = {src.mq[i][QW-2:0], 1'b1};
        end else begin
          nxt.rem[i] = t;
          nxt.mq[i]  = {src.mq[i][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (adv[k]) begin
        vld_r[k] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (adv[k]) st_r[k] <= nxt;
    end
  end

  assign up_ready = adv[0];
  assign dn_valid = vld_r[QW-1];
  assign dn_item  = st_r[QW-1];

endmodule
`default_nettype wire

// ----- rtl/qrt_post.sv -----
// qrt_post: rounding, sign restore, translation, saturation and output register
// depends on qrt_pkg
`timescale 1ns / 1ps
`default_nettype none
module qrt_post import qrt_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire pose_t     pose,
  input  wire logic      up_valid,
  output logic           up_ready,
  input  wire div_item_t up_item,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_t           out_data
);

  localparam logic signed [AW:0] HI = {{(AW-CW+2){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [AW:0] LO = ~HI;

  logic va_r, ov_r, adv_a, adv_b;
  logic [2:0][AW-1:0] val_r;
  logic kind_r, degen_r;
  out_t od_r;

  logic [2:0][AW-1:0] val_nxt;
  logic [QW-1:0] qr;
  logic signed [AW-1:0] sv;
  logic signed [AW:0] tot;
  logic [2:0][CW-1:0] crd;
  logic sat;
  out_t od_nxt;

  assign adv_b    = !ov_r || out_ready;
  assign adv_a    = !va_r || adv_b;
  assign up_ready = adv_a;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qr = up_item.mq[i] + QW'({up_item.rem[i], 1'b0} >= {1'b0, pose.n});
      sv = $signed({1'b0, qr});
      val_nxt[i] = up_item.neg[i] ? -sv : sv;
    end
  end

  always_comb begin
    sat = 1'b0;
    crd = '0;
    for (int i = 0; i < 3; i++) begin
      tot = (AW+1)'($signed(val_r[i]));
      if (kind_r) tot = tot + (AW+1)'($signed(pose.shift[i]));
      if (tot > HI) begin
        crd[i] = HI[CW-1:0];
        sat    = 1'b1;
      end else if (tot < LO) begin
        crd[i] = LO[CW-1:0];
        sat    = 1'b1;
      end else begin
        crd[i] = tot[CW-1:0];
      end
    end
    od_nxt.out_x      = degen_r ? '0 : crd[0];
    od_nxt.out_y      = degen_r ? '0 : crd[1];
    od_nxt.out_z      = degen_r ? '0 : crd[2];
    od_nxt.degenerate = degen_r;
    od_nxt.saturated  = degen_r ? 1'b0 : sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (adv_a) va_r <= up_valid;
      if (adv_b) ov_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_a) begin
      val_r   <= val_nxt;
      kind_r  <= up_item.kind;
      degen_r <= up_item.degen;
    end
    if (adv_b) od_r <= od_nxt;
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

endmodule
`default_nettype wire

// ----- rtl/quaternion_rigid_transform_core.sv -----
// quaternion_rigid_transform_core: top level of the pose transform pipeline
// depends on qrt_pkg, qrt_pose, qrt_mac, qrt_div, qrt_post
//
// usage:
//  - write the pose through cfg_we / cfg_idx / cfg_data while no item is in
//    flight; quaternion is signed Q2.14, translation signed Q16.16
//  - items (kind, x, y, z in Q16.16) enter on in_valid / in_ready; each gives
//    exactly one result on out_valid / out_ready, in order
//  - 73 register stages: four for input register and 34x32 multiply / row sum,
//    one per quotient bit of the 67-stage restoring divider by |q|^2, then
//    round/sign and translate/clip; out_valid comes from the last of them
//  - one item per cycle while out_ready is high; each stage holds a valid bit
//    and moves on when the next stage is empty or moving, so bubbles close up
//  - when the receiver stalls, the output register holds and the pipeline
//    fills behind it; in_ready drops only once every stage is occupied
//  - reset clears all valid bits and loads the identity pose with zero shift
`timescale 1ns / 1ps
`default_nettype none
module quaternion_rigid_transform_core import qrt_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_we,
  input  wire logic [IW-1:0] cfg_idx,
  input  wire logic [CW-1:0] cfg_data,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire in_t           in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output out_t               out_data
);

  pose_t     pose;
  logic      mac_valid, mac_ready, div_valid, div_ready;
  div_item_t mac_item, div_item;

  qrt_pose u_pose (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .pose     (pose)
  );

  qrt_mac u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .pose     (pose),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .dn_valid (mac_valid),
    .dn_ready (mac_ready),
    .dn_item  (mac_item)
  );

  qrt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .n        (pose.n),
    .up_valid (mac_valid),
    .up_ready (mac_ready),
    .up_item  (mac_item),
    .dn_valid (div_valid),
    .dn_ready (div_ready),
    .dn_item  (div_item)
  );

  qrt_post u_post (
    .clk       (clk),
    .rst_n     (rst_n),
    .pose      (pose),
    .up_valid  (div_valid),
    .up_ready  (div_ready),
    .up_item   (div_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ----- tb/sv/testbench.sv -----
// testbench: self-checking bench for quaternion_rigid_transform_core
// depends on qrt_pkg and the core; checks every result against table values or a local pose predictor
`timescale 1ns / 1ps
module testbench;
  import qrt_pkg::*;

  typedef struct {
    logic signed [15:0] rot [4];
    logic signed [31:0] shift [3];
  } tb_pose_t;

  typedef struct {
    int   pose_sel;
    in_t  item;
    bit   typed;
    out_t want;
  } row_t;

  localparam int NUM_POSES = 9;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 100;
  localparam logic [31:0] CMAX = 32'h7fffffff;
  localparam logic [31:0] CMIN = 32'h80000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [IW-1:0] cfg_idx = '0;
  logic [CW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  tb_pose_t cur_pose;
  tb_pose_t pose_list [NUM_POSES];
  out_t pending_results [$];
  int errors = 0;
  int cycles = 0;
  bit no_idle = 1'b0;
  bit hold_req = 1'b0;

  quaternion_rigid_transform_core uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic out_t transform(in_t d, tb_pose_t p);
    longint w, a, b, c, n, s;
    longint m [3][3];
    longint v [3];
    logic signed [127:0] acc, x1, x2;
    logic [127:0] mag, quo, rem, den;
    logic signed [127:0] lim_hi, lim_lo;
    logic [31:0] res [3];
    bit neg, sat;
    out_t r;
    w = p.rot[0]; a = p.rot[1]; b = p.rot[2]; c = p.rot[3];
    n = w * w + a * a + b * b + c * c;
    r = '0;
    if (n == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    v[0] = $signed(d.in_x); v[1] = $signed(d.in_y); v[2] = $signed(d.in_z);
    s = w * w - (a * a + b * b + c * c);
    m[0][0] = s + 2 * a * a;     m[0][1] = 2 * (a * b - w * c); m[0][2] = 2 * (a * c + w * b);
    m[1][0] = 2 * (a * b + w * c); m[1][1] = s + 2 * b * b;     m[1][2] = 2 * (b * c - w * a);
    m[2][0] = 2 * (a * c - w * b); m[2][1] = 2 * (b * c + w * a); m[2][2] = s + 2 * c * c;
    lim_hi = 128'sh7fffffff;
    lim_lo = -128'sh80000000;
    den = n;
    sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) begin
        x1 = m[i][j];
        x2 = v[j];
        acc = acc + x1 * x2;
      end
      neg = acc < 0;
      mag = neg ? -acc : acc;
      quo = mag / den;
      rem = mag % den;
      if (2 * rem >= den) quo = quo + 1;
      acc = neg ? -$signed(quo) : $signed(quo);
      if (d.kind) begin
        x1 = p.shift[i];
        acc = acc + x1;
      end
      if (acc > lim_hi) begin
        acc = lim_hi;
        sat = 1'b1;
      end else if (acc < lim_lo) begin
        acc = lim_lo;
        sat = 1'b1;
      end
      res[i] = acc[31:0];
    end
    r.out_x = res[0];
    r.out_y = res[1];
    r.out_z = res[2];
    r.saturated = sat;
    return r;
  endfunction

  function automatic tb_pose_t make_pose(int w, int x, int y, int z,
                                         logic [31:0] sx, logic [31:0] sy, logic [31:0] sz);
    tb_pose_t p;
    p.rot[0] = 16'(w); p.rot[1] = 16'(x); p.rot[2] = 16'(y); p.rot[3] = 16'(z);
    p.shift[0] = sx; p.shift[1] = sy; p.shift[2] = sz;
    return p;
  endfunction

  function automatic in_t make_item(bit k, logic [31:0] x, logic [31:0] y, logic [31:0] z);
    in_t d;
    d.kind = k; d.in_x = x; d.in_y = y; d.in_z = z;
    return d;
  endfunction

  function automatic logic [31:0] rand_coord(bit tiny);
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0: v = $urandom_range(0, 1) ? CMAX : CMIN;
      1, 2: v = 32'($signed($urandom_range(0, 200)) - 100);
      default: v = $urandom;
    endcase
    if (tiny && v != CMAX && v != CMIN) v = 32'($signed($urandom_range(0, 64)) - 32);
    return v;
  endfunction

  function automatic tb_pose_t rand_pose(bit tiny_rot);
    tb_pose_t p;
    for (int i = 0; i < 4; i++)
      p.rot[i] = tiny_rot ? 16'($signed($urandom_range(0, 6)) - 3) : 16'($urandom);
    for (int i = 0; i < 3; i++)
      p.shift[i] = $urandom_range(0, 3) == 0 ? 32'($urandom) : 32'($urandom_range(0, 65536 * 4));
    return p;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t mismatch %s: expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  // result side: random stalls, one long hold on request
  initial begin
    out_t want;
    @(posedge clk iff rst_n);
    forever begin
      int g;
      g = no_idle ? 0 : $urandom_range(0, 3);
      if (hold_req) begin
        hold_req = 1'b0;
        g = 400;
      end
      if (g > 0) begin
        out_ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result: actual %h", $time, out_data);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("out_x", want.out_x, out_data.out_x);
        check_field("out_y", want.out_y, out_data.out_y);
        check_field("out_z", want.out_z, out_data.out_z);
        check_field("degenerate", want.degenerate, out_data.degenerate);
        check_field("saturated", want.saturated, out_data.saturated);
      end
    end
  end

  // offer one item, wait for its transfer, record the expected result
  task automatic send_item(in_t d, bit typed, out_t want);
    int g;
    g = no_idle ? 0 : $urandom_range(0, 3);
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= d;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(typed ? want : transform(d, cur_pose));
  endtask

  task automatic load_pose(tb_pose_t p);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    for (int i = 0; i < 7; i++) begin
      cfg_we <= 1'b1;
      cfg_idx <= cfg_idx_t'(i);
      cfg_data <= i < 4 ? 32'($signed(p.rot[i])) : p.shift[i - 4];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cur_pose = p;
  endtask

  initial begin
    row_t rows [$];
    out_t t;
    int sel;
    bit tiny;

    pose_list[0] = make_pose(ROT_W_RESET, 0, 0, 0, 0, 0, 0);
    pose_list[1] = make_pose(0, 0, 0, 0, CMAX, CMIN, 32'd5);
    pose_list[2] = make_pose(ROT_W_RESET, 0, 0, 0, CMAX, CMIN, CMAX);
    pose_list[3] = make_pose(0, ROT_W_RESET, 0, 0, CMIN, CMAX, 0);
    pose_list[4] = make_pose(-32768, -32768, -32768, -32768, CMIN, CMIN, CMIN);
    pose_list[5] = make_pose(32767, 32767, 32767, 32767, CMAX, CMAX, CMAX);
    pose_list[6] = make_pose(1, 0, 0, 0, 0, 0, 0);
    pose_list[7] = make_pose(0, 0, 0, -1, 32'd65536, 32'hffff0000, 32'd1);
    pose_list[8] = make_pose(1, 1, 1, 1, 0, 0, 0);
    cur_pose = pose_list[0];

    // identity after reset: output equals input
    rows.push_back('{0, make_item(1, CMAX, CMAX, CMAX), 1, '0});
    rows.push_back('{0, make_item(0, CMIN, CMIN, CMIN), 1, '0});
    rows.push_back('{0, make_item(1, 0, 0, 0), 1, '0});
    rows.push_back('{0, make_item(0, 32'd1, 32'hffffffff, 32'h00010000), 1, '0});
    rows.push_back('{0, make_item(1, CMAX, CMIN, 32'h12345678), 1, '0});
    rows.push_back('{0, make_item(0, 32'haaaaaaaa, 32'h55555555, 32'hffff0000), 1, '0});
    foreach (rows[i]) begin
      rows[i].want.out_x = rows[i].item.in_x;
      rows[i].want.out_y = rows[i].item.in_y;
      rows[i].want.out_z = rows[i].item.in_z;
    end
    // zero quaternion: zero coordinates, no shift, degenerate set
    t = '0;
    t.degenerate = 1'b1;
    rows.push_back('{1, make_item(1, CMAX, CMIN, 32'd7), 1, t});
    rows.push_back('{1, make_item(0, 32'd3, 32'd4, 32'd5), 1, t});
    rows.push_back('{1, make_item(1, 0, 0, 0), 1, t});
    // shift extremes, half turn, extreme quaternions, tiny norm, axis cycle
    rows.push_back('{2, make_item(1, CMAX, CMIN, 32'd1), 0, '0});
    rows.push_back('{2, make_item(1, CMIN, CMAX, CMAX), 0, '0});
    rows.push_back('{2, make_item(0, CMAX, CMIN, 32'd1), 0, '0});
    rows.push_back('{3, make_item(0, CMAX, CMIN, CMIN), 0, '0});
    rows.push_back('{3, make_item(1, CMIN, CMAX, 32'd9), 0, '0});
    rows.push_back('{4, make_item(0, CMAX, CMIN, CMAX), 0, '0});
    rows.push_back('{4, make_item(1, 32'd3, 32'hfffffffd, 32'd1), 0, '0});
    rows.push_back('{5, make_item(1, CMIN, CMIN, CMIN), 0, '0});
    rows.push_back('{5, make_item(0, 32'd100, 32'd200, 32'd300), 0, '0});
    rows.push_back('{6, make_item(1, 32'd5, 32'hfffffffb, CMAX), 0, '0});
    rows.push_back('{7, make_item(1, CMAX, 32'd1, CMIN), 0, '0});
    rows.push_back('{8, make_item(0, 32'd1, 32'd2, 32'd3), 0, '0});

    rst_n <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    sel = 0;
    foreach (rows[i]) begin
      if (rows[i].pose_sel != sel) begin
        sel = rows[i].pose_sel;
        load_pose(pose_list[sel]);
      end
      send_item(rows[i].item, rows[i].typed, rows[i].want);
    end

    for (int ph = 0; ph < 14; ph++) begin
      tiny = (ph % 4 == 3);
      if (ph < NUM_POSES) load_pose(pose_list[ph]);
      else load_pose(rand_pose(tiny));
      no_idle = (ph % 5 == 2);
      if (ph == 4) hold_req = 1'b1;
      for (int k = 0; k < 95; k++)
        send_item(make_item($urandom_range(0, 1), rand_coord(tiny), rand_coord(tiny),
                            rand_coord(tiny)), 0, '0);
    end
    no_idle = 1'b0;
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
